// ===== hdl/scan_code_to_key_code_decoder_unit_defines.svh =====
// assertion macros for the scan code decoder top level
// no dependencies; included by scan_code_to_key_code_decoder_unit.sv
`ifndef SCAN_CODE_TO_KEY_CODE_DECODER_UNIT_DEFINES_SVH
`define SCAN_CODE_TO_KEY_CODE_DECODER_UNIT_DEFINES_SVH

// same-cycle implication
`define SCD_ASSERT_IMPLY(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("scd assertion failed");

// next-cycle implication
`define SCD_ASSERT_NEXT(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("scd assertion failed");

`endif

// ===== hdl/scd_pkg.sv =====
// types, constants and key tables of the scan code decoder
// no dependencies; used by every module of the block
`default_nettype none

package scd_pkg;

  localparam int QueueDepth   = 2;
  localparam int QueuePtrW    = $clog2(QueueDepth);
  localparam int QueueCountW  = $clog2(QueueDepth + 1);
  localparam int TableEntries = 89;

  localparam logic [7:0] ScanPause  = 8'hE1;
  localparam logic [7:0] ScanPrefix = 8'hE0;

  localparam logic [6:0] CodeLShift   = 7'd42;
  localparam logic [6:0] CodeRShift   = 7'd54;
  localparam logic [6:0] CodeCaps     = 7'd58;
  localparam logic [6:0] CodeNum      = 7'd69;
  localparam logic [6:0] CodeScroll   = 7'd70;
  localparam logic [6:0] CodeSymLo    = 7'd2;
  localparam logic [6:0] CodeSymHi    = 7'd53;
  localparam logic [6:0] CodePadLo    = 7'd71;
  localparam logic [6:0] CodePadHi    = 7'd83;

  localparam logic [7:0] KeyNone   = 8'h00;
  localparam logic [7:0] KeyPause  = 8'hA0;
  localparam logic [7:0] KeyAlphaLo = 8'h61;
  localparam logic [7:0] KeyAlphaHi = 8'h7A;

  typedef struct packed {
    logic       pause;
    logic [6:0] code;
    logic       down;
    logic       ext;
    logic       led;
    logic       shift;
    logic       caps;
    logic       num;
    logic       caps_led;
    logic       num_led;
    logic       scroll_led;
  } item_t;

  typedef struct packed {
    logic                   full;
    logic                   not_empty;
    logic [QueueCountW-1:0] count;
  } queue_status_t;

  function automatic logic [7:0] normal_entry(input logic [6:0] code);
    logic [7:0] k;
    unique case (code)
      7'd0:  k = 8'h00;  7'd1:  k = 8'h1B;  7'd2:  k = 8'h31;  7'd3:  k = 8'h32;
      7'd4:  k = 8'h33;  7'd5:  k = 8'h34;  7'd6:  k = 8'h35;  7'd7:  k = 8'h36;
      7'd8:  k = 8'h37;  7'd9:  k = 8'h38;  7'd10: k = 8'h39;  7'd11: k = 8'h30;
      7'd12: k = 8'h2D;  7'd13: k = 8'h3D;  7'd14: k = 8'h08;  7'd15: k = 8'h09;
      7'd16: k = 8'h71;  7'd17: k = 8'h77;  7'd18: k = 8'h65;  7'd19: k = 8'h72;
      7'd20: k = 8'h74;  7'd21: k = 8'h79;  7'd22: k = 8'h75;  7'd23: k = 8'h69;
      7'd24: k = 8'h6F;  7'd25: k = 8'h70;  7'd26: k = 8'h5B;  7'd27: k = 8'h5D;
      7'd28: k = 8'h0A;  7'd29: k = 8'h81;  7'd30: k = 8'h61;  7'd31: k = 8'h73;
      7'd32: k = 8'h64;  7'd33: k = 8'h66;  7'd34: k = 8'h67;  7'd35: k = 8'h68;
      7'd36: k = 8'h6A;  7'd37: k = 8'h6B;  7'd38: k = 8'h6C;  7'd39: k = 8'h3B;
      7'd40: k = 8'h27;  7'd41: k = 8'h60;  7'd42: k = 8'h82;  7'd43: k = 8'h5C;
      7'd44: k = 8'h7A;  7'd45: k = 8'h78;  7'd46: k = 8'h63;  7'd47: k = 8'h76;
      7'd48: k = 8'h62;  7'd49: k = 8'h6E;  7'd50: k = 8'h6D;  7'd51: k = 8'h2C;
      7'd52: k = 8'h2E;  7'd53: k = 8'h2F;  7'd54: k = 8'h83;  7'd55: k = 8'h2A;
      7'd56: k = 8'h85;  7'd57: k = 8'h20;  7'd58: k = 8'h86;  7'd59: k = 8'h87;
      7'd60: k = 8'h88;  7'd61: k = 8'h89;  7'd62: k = 8'h8A;  7'd63: k = 8'h8B;
      7'd64: k = 8'h8C;  7'd65: k = 8'h8D;  7'd66: k = 8'h8E;  7'd67: k = 8'h8F;
      7'd68: k = 8'h90;  7'd69: k = 8'h91;  7'd70: k = 8'h92;  7'd71: k = 8'h93;
      7'd72: k = 8'h94;  7'd73: k = 8'h95;  7'd74: k = 8'h2D;  7'd75: k = 8'h96;
      7'd76: k = 8'h97;  7'd77: k = 8'h98;  7'd78: k = 8'h2B;  7'd79: k = 8'h99;
      7'd80: k = 8'h9A;  7'd81: k = 8'h9B;  7'd82: k = 8'h9C;  7'd83: k = 8'h9D;
      7'd87: k = 8'h9E;  7'd88: k = 8'h9F;
      default: k = KeyNone;
    endcase
    return k;
  endfunction

  function automatic logic [7:0] shifted_entry(input logic [6:0] code);
    logic [7:0] k;
    unique case (code)
      7'd2:  k = 8'h21;  7'd3:  k = 8'h40;  7'd4:  k = 8'h23;  7'd5:  k = 8'h24;
      7'd6:  k = 8'h25;  7'd7:  k = 8'h5E;  7'd8:  k = 8'h26;  7'd9:  k = 8'h2A;
      7'd10: k = 8'h28;  7'd11: k = 8'h29;  7'd12: k = 8'h5F;  7'd13: k = 8'h2B;
      7'd16: k = 8'h51;  7'd17: k = 8'h57;  7'd18: k = 8'h45;  7'd19: k = 8'h52;
      7'd20: k = 8'h54;  7'd21: k = 8'h59;  7'd22: k = 8'h55;  7'd23: k = 8'h49;
      7'd24: k = 8'h4F;  7'd25: k = 8'h50;  7'd26: k = 8'h7B;  7'd27: k = 8'h7D;
      7'd30: k = 8'h41;  7'd31: k = 8'h53;  7'd32: k = 8'h44;  7'd33: k = 8'h46;
      7'd34: k = 8'h47;  7'd35: k = 8'h48;  7'd36: k = 8'h4A;  7'd37: k = 8'h4B;
      7'd38: k = 8'h4C;  7'd39: k = 8'h3A;  7'd40: k = 8'h22;  7'd41: k = 8'h7E;
      7'd43: k = 8'h7C;  7'd44: k = 8'h5A;  7'd45: k = 8'h58;  7'd46: k = 8'h43;
      7'd47: k = 8'h56;  7'd48: k = 8'h42;  7'd49: k = 8'h4E;  7'd50: k = 8'h4D;
      7'd51: k = 8'h3C;  7'd52: k = 8'h3E;  7'd53: k = 8'h3F;  7'd71: k = 8'h37;
      7'd72: k = 8'h38;  7'd73: k = 8'h39;  7'd75: k = 8'h34;  7'd76: k = 8'h35;
      7'd77: k = 8'h36;  7'd79: k = 8'h31;  7'd80: k = 8'h32;  7'd81: k = 8'h33;
      7'd82: k = 8'h30;  7'd83: k = 8'h2E;
      default: k = normal_entry(code);
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/scd_front.sv =====
// front end: accepts scan bytes, tracks lock, shift, prefix and skip state
// depends on scd_pkg; feeds scd_queue
`default_nettype none

module scd_front (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         accept,
  input  wire logic [7:0]   scan_code,
  input  wire logic [2:0]   skip_count,
  output logic              q_wr,
  output scd_pkg::item_t    q_item
);
  import scd_pkg::*;

  logic       shift_held, shift_held_next;
  logic       caps_on, caps_on_next;
  logic       num_on, num_on_next;
  logic       scroll_on, scroll_on_next;
  logic       prefix_pending, prefix_pending_next;
  logic [2:0] skip_left, skip_left_next;
  logic [6:0] code;
  logic       down;

  assign code = scan_code[6:0];
  assign down = ~scan_code[7];

  always_comb begin
    shift_held_next     = shift_held;
    caps_on_next        = caps_on;
    num_on_next         = num_on;
    scroll_on_next      = scroll_on;
    prefix_pending_next = prefix_pending;
    skip_left_next      = skip_left;
    q_wr                = 1'b0;
    q_item              = '0;
    q_item.caps_led     = caps_on;
    q_item.num_led      = num_on;
    q_item.scroll_led   = scroll_on;
    if (accept) begin
      priority if (skip_left != 3'd0) begin
        skip_left_next = skip_left - 3'd1;
      end else if (scan_code == ScanPause) begin
        skip_left_next = skip_count;
        q_wr           = 1'b1;
        q_item.pause   = 1'b1;
        q_item.down    = 1'b1;
      end else if (scan_code == ScanPrefix) begin
        prefix_pending_next = 1'b1;
      end else begin
        q_wr                = 1'b1;
        prefix_pending_next = 1'b0;
        q_item.code         = code;
        q_item.down         = down;
        q_item.ext          = prefix_pending;
        q_item.shift        = shift_held;
        q_item.caps         = caps_on;
        q_item.num          = num_on;
        if (code == CodeLShift || code == CodeRShift) begin
          shift_held_next = down;
        end else if (down && code == CodeCaps) begin
          caps_on_next = ~caps_on;
          q_item.led   = 1'b1;
        end else if (down && code == CodeNum) begin
          num_on_next = ~num_on;
          q_item.led  = 1'b1;
        end else if (down && code == CodeScroll) begin
          scroll_on_next = ~scroll_on;
          q_item.led     = 1'b1;
        end
        q_item.caps_led   = caps_on_next;
        q_item.num_led    = num_on_next;
        q_item.scroll_led = scroll_on_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_held     <= 1'b0;
      caps_on        <= 1'b0;
      num_on         <= 1'b0;
      scroll_on      <= 1'b0;
      prefix_pending <= 1'b0;
      skip_left      <= 3'd0;
    end else begin
      shift_held     <= shift_held_next;
      caps_on        <= caps_on_next;
      num_on         <= num_on_next;
      scroll_on      <= scroll_on_next;
      prefix_pending <= prefix_pending_next;
      skip_left      <= skip_left_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/scd_queue.sv =====
// short item queue between the front end and the decode stage
// depends on scd_pkg
`default_nettype none

module scd_queue (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 wr,
  input  wire scd_pkg::item_t       wr_item,
  input  wire logic                 rd,
  output scd_pkg::item_t            rd_item,
  output scd_pkg::queue_status_t    status
);
  import scd_pkg::*;

  item_t                  mem [QueueDepth];
  logic [QueuePtrW-1:0]   wr_ptr, rd_ptr;
  logic [QueueCountW-1:0] count;

  assign rd_item          = mem[rd_ptr];
  assign status.count     = count;
  assign status.full      = (count == QueueCountW'(QueueDepth));
  assign status.not_empty = (count != '0);

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({wr, rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/scd_back.sv =====
// decode stage: table lookup with shift selection and the result register
// depends on scd_pkg; reads scd_queue
`default_nettype none

module scd_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            q_not_empty,
  input  wire scd_pkg::item_t  q_item,
  output logic                 q_rd,
  input  wire logic            pop,
  output logic                 empty,
  output logic [7:0]           key_code,
  output logic                 key_pressed,
  output logic                 key_extended,
  output logic                 led_update,
  output logic                 caps_led,
  output logic                 num_led,
  output logic                 scroll_led
);
  import scd_pkg::*;

  logic       out_valid;
  logic [7:0] norm;
  logic       alpha;
  logic       use_shifted;
  logic [7:0] key;

  assign norm  = normal_entry(q_item.code);
  assign alpha = (norm >= KeyAlphaLo) && (norm <= KeyAlphaHi);

  always_comb begin
    priority if (alpha) begin
      use_shifted = q_item.shift ^ q_item.caps;
    end else if (q_item.code >= CodeSymLo && q_item.code <= CodeSymHi) begin
      use_shifted = q_item.shift;
    end else if (q_item.code >= CodePadLo && q_item.code <= CodePadHi && !q_item.ext) begin
      use_shifted = q_item.num;
    end else begin
      use_shifted = 1'b0;
    end
    if (q_item.pause) begin
      key = KeyPause;
    end else begin
      key = use_shifted ? shifted_entry(q_item.code) : norm;
    end
  end

  assign q_rd  = q_not_empty && (!out_valid || pop);
  assign empty = ~out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_rd) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      key_code     <= key;
      key_pressed  <= q_item.down;
      key_extended <= q_item.ext;
      led_update   <= q_item.led;
      caps_led     <= q_item.caps_led;
      num_led      <= q_item.num_led;
      scroll_led   <= q_item.scroll_led;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/scan_code_to_key_code_decoder_unit.sv =====
// top level of the set-1 scan code to key code decoder
// depends on scd_pkg, scd_front, scd_queue, scd_back and the defines header
//
//   channel   direction  handshake          payload
//   input     in         push / full        scan_code
//   result    out        pop / empty        key_code, key_pressed, key_extended,
//                                           led_update, caps_led, num_led, scroll_led
//   config    in         apb psel/penable   pause_skip_count at address 0
//
// one scan byte per cycle is accepted while full is low; a result shows on the ports
// after it is written into the queue and then read from it into the output register
// full rises only when the two-entry queue holds items the output register cannot take
// synchronous reset clears all key state and the queue; pause_skip_count resets to 2
`default_nettype none
`include "scan_code_to_key_code_decoder_unit_defines.svh"

module scan_code_to_key_code_decoder_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  scan_code,
  input  wire logic        pop,
  output logic             empty,
  output logic [7:0]       key_code,
  output logic             key_pressed,
  output logic             key_extended,
  output logic             led_update,
  output logic             caps_led,
  output logic             num_led,
  output logic             scroll_led,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import scd_pkg::*;

  logic          [2:0] pause_skip_count;
  logic                accept;
  logic                cfg_wr;
  logic                q_wr;
  logic                q_rd;
  item_t               q_wr_item;
  item_t               q_rd_item;
  queue_status_t       q_status;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? {29'd0, pause_skip_count} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      pause_skip_count <= 3'd2;
    end else if (cfg_wr) begin
      pause_skip_count <= pwdata[2:0];
    end
  end

  assign full   = q_status.full;
  assign accept = push && !full;

  scd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .scan_code  (scan_code),
    .skip_count (pause_skip_count),
    .q_wr       (q_wr),
    .q_item     (q_wr_item)
  );

  scd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_wr),
    .wr_item (q_wr_item),
    .rd      (q_rd),
    .rd_item (q_rd_item),
    .status  (q_status)
  );

  scd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_not_empty  (q_status.not_empty),
    .q_item       (q_rd_item),
    .q_rd         (q_rd),
    .pop          (pop),
    .empty        (empty),
    .key_code     (key_code),
    .key_pressed  (key_pressed),
    .key_extended (key_extended),
    .led_update   (led_update),
    .caps_led     (caps_led),
    .num_led      (num_led),
    .scroll_led   (scroll_led)
  );

  `SCD_ASSERT_IMPLY(a_queue_bound, clk, rst, 1'b1, q_status.count <= QueueCountW'(QueueDepth))
  `SCD_ASSERT_IMPLY(a_led_on_press, clk, rst, !empty && led_update, key_pressed)
  `SCD_ASSERT_IMPLY(a_pause_plain, clk, rst, !empty && key_code == KeyPause,
                    !key_extended && !led_update && key_pressed)
  `SCD_ASSERT_NEXT(a_cfg_write, clk, rst, cfg_wr, pause_skip_count == $past(pwdata[2:0]))

endmodule

`default_nettype wire

// ===== bench/scd_key_checker.sv =====
// checker for the scan code decoder: watches the scan byte, key result and apb channels,
// predicts each key result from its own decoder state and compares field by field
// depends on scd_pkg for key code and scan code constants
module scd_key_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  logic [7:0]  scan_code,
  input  logic        pop,
  input  logic        empty,
  input  logic [7:0]  key_code,
  input  logic        key_pressed,
  input  logic        key_extended,
  input  logic        led_update,
  input  logic        caps_led,
  input  logic        num_led,
  input  logic        scroll_led,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending,
  output int          results_checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import scd_pkg::*;

  localparam logic [2:0] PauseSkipAddr  = 3'd0;
  localparam logic [2:0] PauseSkipReset = 3'd2;
  localparam int         ReportLimit    = 10;

  // key tables, entry 0 in the top byte
  localparam logic [TableEntries*8-1:0] PlainKeys = {
    128'h001B313233343536373839302D3D0809,
    128'h7177657274797569_6F705B5D0A816173,
    128'h6466676_86A6B6C3B2760825C7A786376,
    128'h626E6D2C2E2F832A8520868788898A8B,
    128'h8C8D8E8F9091929394952D969798_2B99,
    72'h9A9B9C9D0000009E9F
  };
  localparam logic [TableEntries*8-1:0] ShiftedKeys = {
    128'h001B21402324255E262A28295F2B0809,
    128'h515745525459554_94F507B7D0A814153,
    128'h4446474_84A4B4C3A227E827C5A584356,
    128'h424E4D3C3E3F832A8520868788898A8B,
    128'h8C8D8E8F90919237383_92D3435362B31,
    72'h3233302E0000009E9F
  };

  typedef struct packed {
    logic [7:0] key;
    logic       down;
    logic       ext;
    logic       led;
    logic       caps;
    logic       num;
    logic       scroll;
  } key_result_t;

  key_result_t expected_keys[$];

  logic       shift_down;
  logic       caps_lock;
  logic       num_lock;
  logic       scroll_lock;
  logic       e0_seen;
  logic [2:0] bytes_to_skip;
  logic [2:0] skip_setting;

  function automatic logic [7:0] table_key(input logic [TableEntries*8-1:0] keys,
                                           input logic [6:0] code);
    if (code >= TableEntries) return KeyNone;
    return keys[(TableEntries - 1 - code) * 8 +: 8];
  endfunction

  function automatic bit decode_scan(input logic [7:0] sc, output key_result_t res);
    logic [6:0] code;
    logic [7:0] plain;
    logic       shifted;
    logic       toggled;
    res = '0;
    if (bytes_to_skip != 3'd0) begin
      bytes_to_skip = bytes_to_skip - 3'd1;
      return 1'b0;
    end
    if (sc == ScanPause) begin
      bytes_to_skip = skip_setting;
      res.key = KeyPause;
      res.down = 1'b1;
      res.caps = caps_lock;
      res.num = num_lock;
      res.scroll = scroll_lock;
      return 1'b1;
    end
    if (sc == ScanPrefix) begin
      e0_seen = 1'b1;
      return 1'b0;
    end
    code = sc[6:0];
    plain = table_key(PlainKeys, code);
    shifted = 1'b0;
    toggled = 1'b0;
    if (plain >= KeyAlphaLo && plain <= KeyAlphaHi) begin
      shifted = shift_down ^ caps_lock;
    end else if (code >= CodeSymLo && code <= CodeSymHi) begin
      shifted = shift_down;
    end else if (code >= CodePadLo && code <= CodePadHi && !e0_seen) begin
      shifted = num_lock;
    end
    res.key = shifted ? table_key(ShiftedKeys, code) : plain;
    res.down = !sc[7];
    res.ext = e0_seen;
    e0_seen = 1'b0;
    // shift follows press and release, lock keys toggle on press only
    if (code == CodeLShift || code == CodeRShift) begin
      shift_down = res.down;
    end else if (res.down && code == CodeCaps) begin
      caps_lock = !caps_lock;
      toggled = 1'b1;
    end else if (res.down && code == CodeNum) begin
      num_lock = !num_lock;
      toggled = 1'b1;
    end else if (res.down && code == CodeScroll) begin
      scroll_lock = !scroll_lock;
      toggled = 1'b1;
    end
    res.led = toggled;
    res.caps = caps_lock;
    res.num = num_lock;
    res.scroll = scroll_lock;
    return 1'b1;
  endfunction

  always @(posedge clk) begin : monitor
    key_result_t got;
    key_result_t want;
    key_result_t fresh;
    if (rst) begin
      shift_down = 1'b0;
      caps_lock = 1'b0;
      num_lock = 1'b0;
      scroll_lock = 1'b0;
      e0_seen = 1'b0;
      bytes_to_skip = 3'd0;
      skip_setting = PauseSkipReset;
      expected_keys.delete();
    end else begin
      if (pop && !empty) begin
        got.key = key_code;
        got.down = key_pressed;
        got.ext = key_extended;
        got.led = led_update;
        got.caps = caps_led;
        got.num = num_led;
        got.scroll = scroll_led;
        if (expected_keys.size() == 0) begin
          fail_count++;
          if (fail_count <= ReportLimit)
            $display("unexpected key result transfer: key %h down %b ext %b", got.key,
                     got.down, got.ext);
        end else begin
          want = expected_keys.pop_front();
          results_checked++;
          if (got !== want) begin
            fail_count++;
            if (fail_count <= ReportLimit)
              $display({"key result mismatch: expected key %h down %b ext %b led %b ",
                        "caps %b num %b scroll %b, got key %h down %b ext %b led %b ",
                        "caps %b num %b scroll %b"},
                       want.key, want.down, want.ext, want.led, want.caps, want.num,
                       want.scroll, got.key, got.down, got.ext, got.led, got.caps,
                       got.num, got.scroll);
          end
        end
      end
      if (push && !full) begin
        if (decode_scan(scan_code, fresh)) expected_keys.push_back(fresh);
      end
      if (psel && penable && pwrite && pready && paddr[2] == PauseSkipAddr[2])
        skip_setting = pwdata[2:0];
    end
    pending = expected_keys.size();
  end

endmodule

// ===== bench/tb_top.sv =====
// top of the scan code decoder testbench: clock, reset, scan byte bursts, result
// stalls, apb pause skip settings; verdict from scd_key_checker fail, pending counts
// depends on scd_pkg, scd_key_checker and scan_code_to_key_code_decoder_unit
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import scd_pkg::*;

  localparam logic [2:0] PauseSkipAddr = 3'd0;
  localparam logic [2:0] SpareAddr     = 3'd4;
  localparam int         SettleCycles  = 6;
  localparam int         PhaseBytes    = 120;
  localparam int         CycleLimit    = 400000;
  localparam int         DirectedCount = 28;

  // directed bytes: plain keys, shift, caps, num lock keypad, prefixed keypad and
  // prefixed shift, scroll lock, last table entry, out of table codes, pause with skip
  localparam logic [DirectedCount*8-1:0] DirectedScans = {
    8'h00, 8'h1E, {1'b0, CodeLShift}, 8'h1E, 8'h02, 8'h47, {1'b1, CodeLShift},
    {1'b0, CodeCaps}, {1'b1, CodeCaps}, 8'h1E, {1'b0, CodeRShift}, 8'h10,
    {1'b1, CodeRShift}, {1'b0, CodeNum}, 8'h47, ScanPrefix, 8'h47, ScanPrefix,
    {1'b0, CodeLShift}, 8'h0B, {1'b0, CodeScroll}, 8'h58, 8'h59, 8'hFF,
    ScanPause, ScanPrefix, ScanPause, 8'hD8
  };

  typedef enum logic [1:0] {PopAlways, PopHalf, PopRare} pop_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic [7:0]  scan_code = 8'h00;
  logic        pop = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic        full;
  logic        empty;
  logic [7:0]  key_code;
  logic        key_pressed;
  logic        key_extended;
  logic        led_update;
  logic        caps_led;
  logic        num_led;
  logic        scroll_led;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          pending;
  int          results_checked;

  int          cycle_count = 0;
  int          burst_left = 0;
  int          bytes_sent = 0;
  logic [2:0]  cur_skip = 3'd2;
  pop_mode_t   pop_mode = PopAlways;
  int          pop_left = 0;

  scan_code_to_key_code_decoder_unit dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .scan_code(scan_code),
    .pop(pop), .empty(empty), .key_code(key_code), .key_pressed(key_pressed),
    .key_extended(key_extended), .led_update(led_update), .caps_led(caps_led),
    .num_led(num_led), .scroll_led(scroll_led), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  scd_key_checker key_check (
    .clk(clk), .rst(rst), .push(push), .full(full), .scan_code(scan_code),
    .pop(pop), .empty(empty), .key_code(key_code), .key_pressed(key_pressed),
    .key_extended(key_extended), .led_update(led_update), .caps_led(caps_led),
    .num_led(num_led), .scroll_led(scroll_led), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .pready(pready),
    .fail_count(fail_count), .pending(pending), .results_checked(results_checked)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  // result side stalls in stretches of its own
  always @(posedge clk) begin
    if (pop_left == 0) begin
      pop_mode <= pop_mode_t'($urandom_range(0, 2));
      pop_left <= $urandom_range(5, 60);
    end else begin
      pop_left <= pop_left - 1;
    end
    case (pop_mode)
      PopAlways: pop <= 1'b1;
      PopHalf:   pop <= 1'($urandom_range(0, 1));
      default:   pop <= ($urandom_range(0, 3) == 0);
    endcase
  end

  task automatic send_scan(input logic [7:0] value);
    if (burst_left == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 8);
    end
    push <= 1'b1;
    scan_code <= value;
    @(negedge clk);
    while (full) @(negedge clk);
    @(posedge clk);
    burst_left--;
    bytes_sent++;
  endtask

  task automatic wait_idle;
    push <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    while (!pready) @(negedge clk);
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_pause_skip(input logic [2:0] value);
    write_reg(PauseSkipAddr, ($urandom() & 32'hFFFF_FFF8) | 32'(value));
    cur_skip = value;
  endtask

  task automatic send_random_event;
    int         pick;
    int         n;
    logic [6:0] code;
    logic       up;
    pick = $urandom_range(0, 99);
    code = 7'($urandom_range(0, TableEntries - 1));
    up = 1'($urandom_range(0, 1));
    if (pick < 45) begin
      send_scan({up, code});
    end else if (pick < 58) begin
      send_scan(ScanPrefix);
      send_scan({up, code});
    end else if (pick < 68) begin
      send_scan({up, ($urandom_range(0, 1) == 0) ? CodeLShift : CodeRShift});
    end else if (pick < 76) begin
      case ($urandom_range(0, 2))
        0:       send_scan({up, CodeCaps});
        1:       send_scan({up, CodeNum});
        default: send_scan({up, CodeScroll});
      endcase
    end else if (pick < 82) begin
      // pause sequence, sometimes cut short or overlong
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : int'(cur_skip);
      send_scan(ScanPause);
      repeat (n) send_scan(8'($urandom_range(0, 255)));
    end else begin
      send_scan(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    int phase_start;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DirectedCount; i++)
      send_scan(DirectedScans[(DirectedCount - 1 - i) * 8 +: 8]);

    for (int phase = 0; phase < 5; phase++) begin
      wait_idle();
      if (phase == 0) write_reg(SpareAddr, $urandom());
      case (phase)
        0:       set_pause_skip(3'd7);
        1:       set_pause_skip(3'd0);
        4:       set_pause_skip(3'd2);
        default: set_pause_skip(3'($urandom_range(1, 6)));
      endcase
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PhaseBytes / 2) send_random_event();
      wait_idle();
      while (bytes_sent - phase_start < PhaseBytes) send_random_event();
    end

    wait_idle();
    repeat (10) @(posedge clk);
    $display("covered %0d scan bytes over six pause skip settings", bytes_sent);
    $display("compared %0d key results in %0d cycles", results_checked, cycle_count);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
